// ===== sv/cdll_pkg.sv =====
// Package for the circular doubly linked list block.
// Holds command and status codes and sizing constants; no dependencies.
package cdll_pkg;
    localparam int DEF_CAPACITY = 64;
    localparam int VAL_W = 32;
    localparam int POS_W = 7;
    localparam int CMD_W = 3;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DUMP_FWD  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_DUMP_REV  = 3'd7;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;
endpackage

// ===== sv/circular_doubly_linked_list.sv =====
// Top level of the circular doubly linked list block.
// Uses cdll_pkg. Link and element memories live here.
//
// Usage: a request on the s_ channel carries a command, a value and a
// 1-based position (tdata, lowest bits first). Results leave on the m_
// channel: element, count, status, with tlast marking the final result of
// a request. Every command except a dump gives one result; a dump gives
// one result per element, or one empty-status result for an empty list.
// Requests are handled one at a time. Error results appear in the cycle
// after the request is taken; a first insert into an empty list passes
// S_WAITW. A back insert passes S_LINK, S_LINK2 and S_WAITW; one elsewhere
// walks and adds S_RDP, and a delete walks and passes S_RDP and S_DLINK.
// A walk hop reads a link in S_WALK and waits in S_WAITW. Front commands
// are the p = 1 case and a back delete walks the whole list. A dump passes
// S_DRD (read), S_DRDL (read latency) and S_DOUT (output) per element, so
// a full-list dump is the longest request. The free-slot map is a flip-flop
// vector with a priority search. Reset (aresetn low, synchronous) empties
// the list at once; no clearing pass is needed. While the receiver holds
// m_tready low, the result stays registered and the block waits; s_tready
// returns the cycle after the last result has been taken.
module circular_doubly_linked_list
    import cdll_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], value[34:3], position[41:35], zero fill to 48
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // element[31:0], count[38:32], status[40:39], zero fill to 48
    output logic [47:0] m_tdata,
    output logic        m_tlast
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WALK  = 4'd1;
    localparam logic [3:0] S_WAITW = 4'd2;
    localparam logic [3:0] S_RDP   = 4'd3;
    localparam logic [3:0] S_LINK  = 4'd4;
    localparam logic [3:0] S_LINK2 = 4'd5;
    localparam logic [3:0] S_DLINK = 4'd6;
    localparam logic [3:0] S_DRD   = 4'd7;
    localparam logic [3:0] S_DOUT  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_DRDL  = 4'd10;

    logic [VAL_W-1:0] elem_mem [CAPACITY];
    logic [AW-1:0]    next_mem [CAPACITY];
    logic [AW-1:0]    prev_mem [CAPACITY];

    logic [3:0]        state_reg, state_next;
    logic [CAPACITY-1:0] free_reg, free_next;
    logic [AW-1:0]     head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  hop_reg, hop_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     new_reg, new_next;
    logic [AW-1:0]     pred_reg, pred_next;
    logic [AW-1:0]     succ_reg, succ_next;
    logic              ins_reg, ins_next;
    logic              ovalid_reg, ovalid_next;
    logic              olast_reg, olast_next;
    logic [VAL_W-1:0]  oelem_reg, oelem_next;
    logic [ST_W-1:0]   ost_reg, ost_next;

    // Memory port controls.
    logic              lrd;
    logic [AW-1:0]     lrd_addr;
    logic [AW-1:0]     nx_q, pv_q;
    logic              nwe, pwe, ewe;
    logic [AW-1:0]     nwa, pwa;
    logic [AW-1:0]     nwd, pwd;
    logic              erd;
    logic [VAL_W-1:0]  el_q;

    logic [CMD_W-1:0]  in_cmd;
    logic [VAL_W-1:0]  in_val;
    logic [POS_W-1:0]  in_pos;
    logic [AW-1:0]     free_slot;
    logic [POS_W:0]    cnt_ext;

    assign in_cmd = s_tdata[2:0];
    assign in_val = s_tdata[34:3];
    assign in_pos = s_tdata[41:35];
    assign cnt_ext = (POS_W+1)'(cnt_reg);

    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                free_slot = AW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (nwe) begin
            next_mem[nwa] <= nwd;
        end
        if (pwe) begin
            prev_mem[pwa] <= pwd;
        end
        if (ewe) begin
            elem_mem[new_reg] <= val_reg;
        end
        if (lrd) begin
            nx_q <= next_mem[lrd_addr];
            pv_q <= prev_mem[lrd_addr];
        end
        if (erd) begin
            el_q <= elem_mem[cur_reg];
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {7'd0, ost_reg, 7'(cnt_reg), oelem_reg};

    always_comb begin
        logic          accept;
        logic [POS_W:0] p;
        logic          is_ins;
        logic [AW-1:0] step;
        accept = 1'b0;
        p = '0;
        is_ins = 1'b0;
        step = '0;
        state_next = state_reg;
        free_next = free_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next = cnt_reg;
        cmd_next = cmd_reg;
        val_next = val_reg;
        pos_next = pos_reg;
        hop_next = hop_reg;
        cur_next = cur_reg;
        new_next = new_reg;
        pred_next = pred_reg;
        succ_next = succ_reg;
        ins_next = ins_reg;
        ovalid_next = ovalid_reg;
        olast_next = olast_reg;
        oelem_next = oelem_reg;
        ost_next = ost_reg;
        lrd = 1'b0;
        lrd_addr = cur_reg;
        nwe = 1'b0; pwe = 1'b0; ewe = 1'b0;
        nwa = '0; pwa = '0; nwd = '0; pwd = '0;
        erd = 1'b0;

        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                accept = s_tvalid && !ovalid_reg;
                if (accept) begin
                    cmd_next = in_cmd;
                    val_next = in_val;
                    oelem_next = '0;
                    olast_next = 1'b1;
                    is_ins = (in_cmd == CMD_INS_FRONT) || (in_cmd == CMD_INS_BACK)
                             || (in_cmd == CMD_INS_POS);
                    ins_next = is_ins;
                    case (in_cmd)
                        CMD_INS_FRONT: p = (POS_W+1)'(1);
                        CMD_INS_BACK:  p = cnt_ext + 1'b1;
                        CMD_INS_POS:   p = {1'b0, in_pos};
                        CMD_DEL_FRONT: p = (POS_W+1)'(1);
                        CMD_DEL_BACK:  p = cnt_ext;
                        CMD_DEL_POS:   p = {1'b0, in_pos};
                        default:       p = '0;
                    endcase
                    pos_next = POS_W'(p);
                    new_next = free_slot;
                    if (in_cmd == CMD_DUMP_FWD || in_cmd == CMD_DUMP_REV) begin
                        if (cnt_reg == '0) begin
                            ost_next = ST_EMPTY;
                            ovalid_next = 1'b1;
                        end else begin
                            cur_next = (in_cmd == CMD_DUMP_FWD) ? head_reg : tail_reg;
                            hop_next = POS_W'(1);
                            state_next = S_DRD;
                        end
                    end else if (is_ins) begin
                        if (p == '0 || p > cnt_ext + 1'b1) begin
                            ost_next = ST_BADPOS;
                            ovalid_next = 1'b1;
                        end else if (cnt_ext >= (POS_W+1)'(CAPACITY)) begin
                            ost_next = ST_FULL;
                            ovalid_next = 1'b1;
                        end else if (cnt_reg == '0) begin
                            // First element links to itself.
                            free_next[free_slot] = 1'b0;
                            head_next = free_slot;
                            tail_next = free_slot;
                            cnt_next = cnt_reg + 1'b1;
                            nwe = 1'b1; nwa = free_slot; nwd = free_slot;
                            pwe = 1'b1; pwa = free_slot; pwd = free_slot;
                            hop_next = POS_W'(p);
                            state_next = S_WAITW;
                        end else if (p == cnt_ext + 1'b1) begin
                            succ_next = head_reg;
                            pred_next = tail_reg;
                            state_next = S_LINK;
                        end else begin
                            cur_next = head_reg;
                            hop_next = POS_W'(1);
                            state_next = S_WALK;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            ost_next = ST_EMPTY;
                            ovalid_next = 1'b1;
                        end else if (p == '0 || p > cnt_ext) begin
                            ost_next = ST_BADPOS;
                            ovalid_next = 1'b1;
                        end else begin
                            cur_next = head_reg;
                            hop_next = POS_W'(1);
                            state_next = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                // One link read per hop until the target slot is in cur_reg.
                if (hop_reg == pos_reg) begin
                    lrd = 1'b1;
                    lrd_addr = cur_reg;
                    state_next = S_RDP;
                end else begin
                    lrd = 1'b1;
                    lrd_addr = cur_reg;
                    state_next = S_WAITW;
                end
            end
            S_WAITW: begin
                if (cmd_reg == CMD_DUMP_FWD || cmd_reg == CMD_DUMP_REV) begin
                    state_next = S_DRD;
                end else if (state_reg == S_WAITW && hop_reg != pos_reg) begin
                    cur_next = nx_q;
                    hop_next = hop_reg + 1'b1;
                    state_next = S_WALK;
                end else begin
                    ewe = ins_reg;
                    ost_next = ST_OK;
                    ovalid_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_RDP: begin
                if (ins_reg) begin
                    succ_next = cur_reg;
                    pred_next = pv_q;
                    if (pos_reg == POS_W'(1)) begin
                        head_next = new_reg;
                    end
                    state_next = S_LINK;
                end else begin
                    pred_next = pv_q;
                    succ_next = nx_q;
                    state_next = S_DLINK;
                end
            end
            S_LINK: begin
                free_next[new_reg] = 1'b0;
                if (pos_reg == POS_W'(cnt_ext + 1'b1)) begin
                    tail_next = new_reg;
                end
                nwe = 1'b1; nwa = new_reg; nwd = succ_reg;
                pwe = 1'b1; pwa = new_reg; pwd = pred_reg;
                state_next = S_LINK2;
            end
            S_LINK2: begin
                nwe = 1'b1; nwa = pred_reg; nwd = new_reg;
                pwe = 1'b1; pwa = succ_reg; pwd = new_reg;
                cnt_next = cnt_reg + 1'b1;
                hop_next = pos_reg;
                state_next = S_WAITW;
            end
            S_DLINK: begin
                free_next[cur_reg] = 1'b1;
                if (cnt_reg == CW'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end else begin
                    nwe = 1'b1; nwa = pred_reg; nwd = succ_reg;
                    pwe = 1'b1; pwa = succ_reg; pwd = pred_reg;
                    if (cur_reg == head_reg) begin
                        head_next = succ_reg;
                    end
                    if (cur_reg == tail_reg) begin
                        tail_next = pred_reg;
                    end
                end
                cnt_next = cnt_reg - 1'b1;
                ost_next = ST_OK;
                ovalid_next = 1'b1;
                state_next = S_OUT;
            end
            S_DRD: begin
                // Read the element and its onward link together.
                if (!ovalid_reg || m_tready) begin
                    erd = 1'b1;
                    lrd = 1'b1;
                    lrd_addr = cur_reg;
                    state_next = S_DRDL;
                end
            end
            S_DRDL: begin
                state_next = S_DOUT;
            end
            S_DOUT: begin
                if (!ovalid_reg || m_tready) begin
                    oelem_next = el_q;
                    ost_next = ST_OK;
                    olast_next = (POS_W+1)'(hop_reg) == cnt_ext;
                    ovalid_next = 1'b1;
                    step = (cmd_reg == CMD_DUMP_FWD) ? nx_q : pv_q;
                    cur_next = step;
                    hop_next = hop_reg + 1'b1;
                    state_next = ((POS_W+1)'(hop_reg) == cnt_ext) ? S_OUT : S_DRD;
                end
            end
            S_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    state_next = S_IDLE;
                    ovalid_next = ovalid_reg && !m_tready;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            free_reg   <= '1;
            head_reg   <= '0;
            tail_reg   <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            ins_reg    <= 1'b0;
            cmd_reg    <= CMD_INS_FRONT;
        end else begin
            state_reg  <= state_next;
            free_reg   <= free_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
            ins_reg    <= ins_next;
            cmd_reg    <= cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        hop_reg   <= hop_next;
        cur_reg   <= cur_next;
        new_reg   <= new_next;
        pred_reg  <= pred_next;
        succ_reg  <= succ_next;
        olast_reg <= olast_next;
        oelem_reg <= oelem_next;
        ost_reg   <= ost_next;
    end
endmodule

// ===== sv/cdll_checker.sv =====
// Port-level checker for the circular doubly linked list block.
// Uses cdll_pkg; bound to the top level below.
module cdll_checker
    import cdll_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);
    // A stalled result holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // No new request is taken while a result is still on offer.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request accepted with result pending");

    // The count in a result never exceeds DEF_CAPACITY.
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[38:32] <= 7'(DEF_CAPACITY))
        else $error("count out of range");

    // Only dumps give non-zero elements; non-ok results carry zero and tlast.
    a_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[40:39] != ST_OK |-> m_tdata[31:0] == '0 && m_tlast)
        else $error("error result malformed");
endmodule

bind circular_doubly_linked_list cdll_checker u_cdll_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
